/* design/tcl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// Package for the thermocouple code linearizer: widths, scaling constants,
// breakpoint segment tables per sensor type, and the control struct that
// travels with each item. No dependencies.
package tcl_pkg;

    localparam int ADC_BITS = 18;

    // Sensor type register codes
    localparam logic [1:0] TYPE_K      = 2'd0;
    localparam logic [1:0] TYPE_J      = 2'd1;
    localparam logic [1:0] TYPE_T      = 2'd2;
    localparam logic [1:0] TYPE_UNUSED = 2'd3;

    localparam int DIV_K  = 221;
    localparam int DIV_J  = 282;
    localparam int DIV_TP = 218;
    localparam int DIV_TN = 217;

    localparam logic [15:0] BASE_OFFSET = 16'd320;
    localparam logic [15:0] T_NEG_REF   = 16'd694;
    localparam logic [15:0] T_NEG_KNEE  = 16'd231;
    localparam int          T_NEG_DIV   = 24;
    localparam logic [15:0] T_POS_LIMIT = 16'd11000;
    localparam logic [15:0] T_NEG_LIMIT = 16'd5000;

    // Front scaling: n = val*100 (+ rounding term), q = floor(n / divisor)
    // by reciprocal multiply, exact for every NUM_W-bit numerator.
    localparam int NUM_W  = ADC_BITS + 6;
    localparam int DSH    = NUM_W + 9;
    localparam int DM_W   = DSH - 7;
    localparam int PROD_W = NUM_W + DM_W + 1;

    localparam logic [63:0] DM_K  = ((64'd1 << DSH) + 64'(DIV_K) - 64'd1) / 64'(DIV_K);
    localparam logic [63:0] DM_J  = ((64'd1 << DSH) + 64'(DIV_J) - 64'd1) / 64'(DIV_J);
    localparam logic [63:0] DM_TP = ((64'd1 << DSH) + 64'(DIV_TP) - 64'd1) / 64'(DIV_TP);
    localparam logic [63:0] DM_TN = ((64'd1 << DSH) + 64'(DIV_TN) - 64'd1) / 64'(DIV_TN);

    // Reciprocal for the type T negative knee step
    localparam int          M24_SH = 16 + $clog2(T_NEG_DIV);
    localparam logic [16:0] M24    =
        17'(((64'd1 << M24_SH) + 64'(T_NEG_DIV) - 64'd1) / 64'(T_NEG_DIV));

    // Breakpoint segments, one pipeline stage per entry
    localparam int NSEG   = 30;
    localparam int K_CNT  = 30;
    localparam int J_CNT  = 16;
    localparam int TN_CNT = 17;
    localparam int TP_CNT = 9;

    localparam int K_THR [NSEG] = '{
        760, 1350, 2450, 3268, 4200, 4950, 5500, 6586, 7680, 9343,
        11120, 12310, 12860, 13780, 14330, 15050, 15850, 16704, 17480, 18250,
        19246, 20126, 20810, 21810, 22570, 23020, 23556, 24350, 24560, 25000};
    localparam int K_OFF [NSEG] = '{
        700, 1250, 2350, 3150, 4100, 4800, 5450, 6460, 7600, 9220,
        11030, 12240, 12680, 13540, 14300, 14900, 15660, 16580, 17280, 18100,
        19160, 20100, 20740, 21760, 22480, 22840, 23440, 24300, 24420, 24860};
    localparam int K_SLP [NSEG] = '{
        36, 76, 56, 48, 88, 64, 88, 76, 120, 200,
        200, 200, 120, 120, 200, 104, 88, 88, 88, 76,
        64, 88, 48, 56, 56, 76, 48, 56, 56, 64};
    localparam logic K_SUB [NSEG] = '{
        1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};

    localparam int J_THR [NSEG] = '{
        854, 1340, 1610, 2445, 3698, 5668, 7260, 8430, 9550, 10550,
        10950, 11550, 12355, 13193, 14050, 14920, 0, 0, 0, 0,
        0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    localparam int J_OFF [NSEG] = '{
        730, 1250, 1530, 2330, 3550, 5450, 7160, 8260, 9450, 10470,
        10850, 11480, 12240, 13050, 13950, 14750, 0, 0, 0, 0,
        0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    localparam int J_SLP [NSEG] = '{
        32, 48, 160, 52, 112, 200, 255, 160, 112, 112,
        112, 52, 52, 52, 48, 112, 1, 1, 1, 1,
        1, 1, 1, 1, 1, 1, 1, 1, 1, 1};
    localparam logic J_SUB [NSEG] = '{
        1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1,
        1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

    localparam int TN_THR [NSEG] = '{
        110, 437, 600, 734, 960, 1150, 1350, 1540, 1780, 1910,
        2180, 2280, 2550, 2720, 2890, 2970, 3150, 0, 0, 0,
        0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    localparam int TN_OFF [NSEG] = '{
        100, 420, 550, 710, 950, 1100, 1300, 1520, 1750, 1900,
        2160, 2270, 2520, 2600, 2850, 2840, 3130, 0, 0, 0,
        0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    localparam int TN_SLP [NSEG] = '{
        16, 48, 32, 24, 32, 24, 32, 16, 24, 16,
        16, 16, 32, 16, 10, 48, 10, 1, 1, 1,
        1, 1, 1, 1, 1, 1, 1, 1, 1, 1};

    localparam int TP_THR [NSEG] = '{
        680, 940, 1300, 1720, 2170, 2610, 2980, 3511, 3984, 0,
        0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
        0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    localparam int TP_OFF [NSEG] = '{
        610, 910, 1270, 1700, 2150, 2580, 2960, 3410, 3870, 0,
        0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
        0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    localparam int TP_SLP [NSEG] = '{
        32, 24, 24, 24, 28, 32, 32, 32, 48, 1,
        1, 1, 1, 1, 1, 1, 1, 1, 1, 1,
        1, 1, 1, 1, 1, 1, 1, 1, 1, 1};

    typedef enum logic [2:0] {
        MODE_NONE,
        MODE_K,
        MODE_J,
        MODE_TP,
        MODE_TN
    } mode_t;

    typedef enum logic [1:0] {
        LIM_NONE,
        LIM_POS,
        LIM_NEG
    } lim_t;

    typedef enum logic [1:0] {
        DSEL_K,
        DSEL_J,
        DSEL_TP,
        DSEL_TN
    } dsel_t;

    typedef struct packed {
        mode_t mode;       // segment chain to run
        lim_t  lim;        // range limit applied at the end
        logic  qneg;       // scaled value is 320 minus quotient
        logic  tn;         // type T negative branch
        logic  tn_small;   // negative magnitude at or below the reference
        logic  below;
        logic  above;
        logic  force_err;  // result forced to zero with error
        logic  dead;       // unused sensor type
    } ctl_t;

endpackage
`default_nettype wire

/* design/thermocouple_code_linearizer.sv */
`timescale 1ns / 1ps
`default_nettype none
// Throughput one item per cycle while no result is held under out_stall.
// Five front stages (entry, split reciprocal multiply, scaling, knee multiply,
// knee add), one stage per breakpoint segment (30), one output register.
// The whole pipeline holds while a result waits under out_stall.
// Reset (rst_n low, async) clears all valid bits and sets sensor_type to K.
// Depends on tcl_pkg.
module thermocouple_code_linearizer (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [1:0]                           sensor_type,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [tcl_pkg::ADC_BITS-1:0]  adc_code,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [15:0]                               temperature,
    output logic                                      below_zero_input,
    output logic                                      above_reference,
    output logic                                      range_error,
    output logic [15:0]                               scaled_code
);

    localparam int AW    = tcl_pkg::ADC_BITS;
    localparam int NW    = tcl_pkg::NUM_W;
    localparam int MHW   = tcl_pkg::DM_W - 16;
    localparam int PW    = tcl_pkg::PROD_W;
    localparam int NSEG  = tcl_pkg::NSEG;

    logic [1:0] sensor_type_reg;
    logic       adv;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_type_reg <= tcl_pkg::TYPE_K;
        end
        else if (cfg_valid && cfg_ready)
        begin
            sensor_type_reg <= sensor_type;
        end
    end

    // Whole pipeline advances unless a result is held at the output
    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    // ---------------- entry decode ----------------
    logic [AW-1:0]       code_u;
    logic                neg;
    logic [AW-1:0]       mag;
    logic [15:0]         m16;
    logic                near_ref;
    logic [NW-1:0]       n_next;
    tcl_pkg::dsel_t      dsel_next;
    tcl_pkg::ctl_t       ctl_next;

    always_comb
    begin
        code_u    = adc_code;
        neg       = code_u[AW-1];
        mag       = neg ? (~code_u + AW'(1)) : code_u;
        m16       = ~code_u[15:0];
        near_ref  = (m16 <= tcl_pkg::T_NEG_REF);
        n_next    = NW'(mag) * NW'(100);
        dsel_next = tcl_pkg::DSEL_K;
        ctl_next  = '0;
        ctl_next.mode = tcl_pkg::MODE_NONE;
        ctl_next.lim  = tcl_pkg::LIM_NONE;
        unique case (sensor_type_reg)
            tcl_pkg::TYPE_K:
            begin
                n_next        = NW'(mag) * NW'(100) + (neg ? NW'(tcl_pkg::DIV_K - 1) : '0);
                ctl_next.mode = tcl_pkg::MODE_K;
                ctl_next.qneg = neg;
            end
            tcl_pkg::TYPE_J:
            begin
                n_next        = NW'(mag) * NW'(100) + (neg ? NW'(tcl_pkg::DIV_J - 1) : '0);
                dsel_next     = tcl_pkg::DSEL_J;
                ctl_next.mode = tcl_pkg::MODE_J;
                ctl_next.qneg = neg;
            end
            tcl_pkg::TYPE_T:
            begin
                if (neg)
                begin
                    n_next            = NW'(m16) * NW'(100)
                                        + (near_ref ? NW'(tcl_pkg::DIV_TN - 1) : '0);
                    dsel_next         = tcl_pkg::DSEL_TN;
                    ctl_next.mode     = near_ref ? tcl_pkg::MODE_NONE : tcl_pkg::MODE_TN;
                    ctl_next.lim      = tcl_pkg::LIM_NEG;
                    ctl_next.tn       = 1'b1;
                    ctl_next.tn_small = near_ref;
                    ctl_next.below    = 1'b1;
                    ctl_next.above    = !near_ref;
                end
                else
                begin
                    dsel_next = tcl_pkg::DSEL_TP;
                    // code above the positive limit: keep scaling, drop the chain
                    if (mag > AW'(tcl_pkg::T_POS_LIMIT))
                    begin
                        ctl_next.force_err = 1'b1;
                    end
                    else
                    begin
                        ctl_next.mode = tcl_pkg::MODE_TP;
                        ctl_next.lim  = tcl_pkg::LIM_POS;
                    end
                end
            end
            default:
            begin
                n_next             = '0;
                ctl_next.force_err = 1'b1;
                ctl_next.dead      = 1'b1;
            end
        endcase
    end

    // ---------------- front stages ----------------
    logic                 v0_reg, v1_reg, v2_reg, v3_reg;
    tcl_pkg::ctl_t        ctl0_reg, ctl1_reg, ctl2_reg, ctl3_reg;
    logic [NW-1:0]        n0_reg;
    tcl_pkg::dsel_t       dsel0_reg;
    logic [NW+15:0]       plo1_reg;
    logic [NW+MHW-1:0]    phi1_reg;
    logic [15:0]          t2_reg, t3_reg;
    logic [32:0]          p24_3_reg;

    logic [63:0]          dm_sel;
    logic [NW+15:0]       plo_next;
    logic [NW+MHW-1:0]    phi_next;
    logic [PW-1:0]        prod_s2;
    logic [15:0]          q_s2;
    logic [15:0]          t2_next;
    logic [15:0]          x24;
    logic [32:0]          p24_next;
    logic [15:0]          q24;
    logic [15:0]          acc4_next;

    always_comb
    begin
        unique case (dsel0_reg)
            tcl_pkg::DSEL_K:  dm_sel = tcl_pkg::DM_K;
            tcl_pkg::DSEL_J:  dm_sel = tcl_pkg::DM_J;
            tcl_pkg::DSEL_TP: dm_sel = tcl_pkg::DM_TP;
            tcl_pkg::DSEL_TN: dm_sel = tcl_pkg::DM_TN;
            default:          dm_sel = tcl_pkg::DM_K;
        endcase
        plo_next = (NW+16)'(n0_reg) * (NW+16)'(dm_sel[15:0]);
        phi_next = (NW+MHW)'(n0_reg) * (NW+MHW)'(dm_sel[tcl_pkg::DM_W-1:16]);
    end

    always_comb
    begin
        prod_s2 = (PW'(phi1_reg) << 16) + PW'(plo1_reg);
        q_s2    = 16'(prod_s2 >> tcl_pkg::DSH);
        if (ctl1_reg.dead)
        begin
            t2_next = '0;
        end
        else if (ctl1_reg.tn)
        begin
            t2_next = ctl1_reg.tn_small ? (tcl_pkg::BASE_OFFSET - q_s2)
                                        : (q_s2 - tcl_pkg::BASE_OFFSET);
        end
        else
        begin
            t2_next = ctl1_reg.qneg ? (tcl_pkg::BASE_OFFSET - q_s2)
                                    : (q_s2 + tcl_pkg::BASE_OFFSET);
        end
    end

    always_comb
    begin
        x24      = ctl2_reg.tn_small ? (tcl_pkg::T_NEG_KNEE - t2_reg)
                                     : (t2_reg + tcl_pkg::T_NEG_KNEE);
        p24_next = 33'(x24) * 33'(tcl_pkg::M24);
    end

    always_comb
    begin
        q24 = 16'(p24_3_reg >> tcl_pkg::M24_SH);
        if (ctl3_reg.tn)
        begin
            acc4_next = ctl3_reg.tn_small ? (t3_reg - q24) : (t3_reg + q24);
        end
        else
        begin
            acc4_next = t3_reg;
        end
    end

    // ---------------- segment chain storage ----------------
    logic          cv_reg      [NSEG+1];
    tcl_pkg::ctl_t cctl_reg    [NSEG+1];
    logic [15:0]   cacc_reg    [NSEG+1];
    logic [15:0]   cbase_reg   [NSEG+1];
    logic [15:0]   cscaled_reg [NSEG+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            cv_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg    <= in_valid;
            v1_reg    <= v0_reg;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            cv_reg[0] <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl0_reg       <= ctl_next;
            n0_reg         <= n_next;
            dsel0_reg      <= dsel_next;
            ctl1_reg       <= ctl0_reg;
            plo1_reg       <= plo_next;
            phi1_reg       <= phi_next;
            ctl2_reg       <= ctl1_reg;
            t2_reg         <= t2_next;
            ctl3_reg       <= ctl2_reg;
            t3_reg         <= t2_reg;
            p24_3_reg      <= p24_next;
            cctl_reg[0]    <= ctl3_reg;
            cacc_reg[0]    <= acc4_next;
            cbase_reg[0]   <= acc4_next;
            cscaled_reg[0] <= t3_reg;
        end
    end

    // ---------------- one stage per breakpoint segment ----------------
    for (genvar g = 0; g < NSEG; g++)
    begin : g_seg
        localparam int          KD    = tcl_pkg::K_SLP[g];
        localparam int          K_SH  = 16 + $clog2(KD);
        localparam logic [16:0] K_M   =
            17'(((64'd1 << K_SH) + 64'(KD) - 64'd1) / 64'(KD));
        localparam int          JD    = tcl_pkg::J_SLP[g];
        localparam int          J_SH  = 16 + $clog2(JD);
        localparam logic [16:0] J_M   =
            17'(((64'd1 << J_SH) + 64'(JD) - 64'd1) / 64'(JD));
        localparam int          PD    = tcl_pkg::TP_SLP[g];
        localparam int          TP_SH = 16 + $clog2(PD);
        localparam logic [16:0] TP_M  =
            17'(((64'd1 << TP_SH) + 64'(PD) - 64'd1) / 64'(PD));
        localparam int          ND    = tcl_pkg::TN_SLP[g];
        localparam int          TN_SH = 16 + $clog2(ND);
        localparam logic [16:0] TN_M  =
            17'(((64'd1 << TN_SH) + 64'(ND) - 64'd1) / 64'(ND));

        logic        en;
        logic        sub;
        logic        running;
        logic [15:0] thr;
        logic [15:0] off;
        logic [16:0] mul;
        logic [15:0] x;
        logic [15:0] diff;
        logic [32:0] prod;
        logic [15:0] q;
        logic [15:0] acc_next;

        always_comb
        begin
            en      = 1'b0;
            sub     = 1'b0;
            running = 1'b0;
            thr     = '0;
            off     = '0;
            mul     = '0;
            unique case (cctl_reg[g].mode)
                tcl_pkg::MODE_K:
                begin
                    en  = (g < tcl_pkg::K_CNT);
                    sub = tcl_pkg::K_SUB[g];
                    thr = 16'(tcl_pkg::K_THR[g]);
                    off = 16'(tcl_pkg::K_OFF[g]);
                    mul = K_M;
                end
                tcl_pkg::MODE_J:
                begin
                    en  = (g < tcl_pkg::J_CNT);
                    sub = tcl_pkg::J_SUB[g];
                    thr = 16'(tcl_pkg::J_THR[g]);
                    off = 16'(tcl_pkg::J_OFF[g]);
                    mul = J_M;
                end
                tcl_pkg::MODE_TP:
                begin
                    en      = (g < tcl_pkg::TP_CNT);
                    sub     = 1'b1;
                    running = 1'b1;
                    thr     = 16'(tcl_pkg::TP_THR[g]);
                    off     = 16'(tcl_pkg::TP_OFF[g]);
                    mul     = TP_M;
                end
                tcl_pkg::MODE_TN:
                begin
                    en      = (g < tcl_pkg::TN_CNT);
                    running = 1'b1;
                    thr     = 16'(tcl_pkg::TN_THR[g]);
                    off     = 16'(tcl_pkg::TN_OFF[g]);
                    mul     = TN_M;
                end
                default:
                begin
                    en = 1'b0;
                end
            endcase

            // K and J test the fixed scaled value, T tests the running value
            x    = running ? cacc_reg[g] : cbase_reg[g];
            diff = x - off;
            prod = 33'(diff) * 33'(mul);

            unique case (cctl_reg[g].mode)
                tcl_pkg::MODE_K:  q = 16'(prod >> K_SH);
                tcl_pkg::MODE_J:  q = 16'(prod >> J_SH);
                tcl_pkg::MODE_TP: q = 16'(prod >> TP_SH);
                tcl_pkg::MODE_TN: q = 16'(prod >> TN_SH);
                default:          q = '0;
            endcase

            if (en && (x > thr))
            begin
                acc_next = sub ? (cacc_reg[g] - q) : (cacc_reg[g] + q);
            end
            else
            begin
                acc_next = cacc_reg[g];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cv_reg[g+1] <= 1'b0;
            end
            else if (adv)
            begin
                cv_reg[g+1] <= cv_reg[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cctl_reg[g+1]    <= cctl_reg[g];
                cacc_reg[g+1]    <= acc_next;
                cbase_reg[g+1]   <= cbase_reg[g];
                cscaled_reg[g+1] <= cscaled_reg[g];
            end
        end
    end

    // ---------------- range limits and output register ----------------
    logic [15:0] temp_next;
    logic        err_next;

    always_comb
    begin
        temp_next = cacc_reg[NSEG];
        err_next  = 1'b0;
        if (cctl_reg[NSEG].force_err)
        begin
            temp_next = '0;
            err_next  = 1'b1;
        end
        else
        begin
            unique case (cctl_reg[NSEG].lim)
                tcl_pkg::LIM_POS:
                begin
                    if (cacc_reg[NSEG] > tcl_pkg::T_POS_LIMIT)
                    begin
                        temp_next = '0;
                        err_next  = 1'b1;
                    end
                end
                tcl_pkg::LIM_NEG:
                begin
                    if (cacc_reg[NSEG] > tcl_pkg::T_NEG_LIMIT)
                    begin
                        temp_next = '0;
                        err_next  = 1'b1;
                    end
                end
                default:
                begin
                    err_next = 1'b0;
                end
            endcase
        end
    end

    logic        out_valid_reg;
    logic [15:0] temperature_reg;
    logic        below_reg;
    logic        above_reg;
    logic        err_reg;
    logic [15:0] scaled_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= cv_reg[NSEG];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            temperature_reg <= temp_next;
            below_reg       <= cctl_reg[NSEG].below;
            above_reg       <= cctl_reg[NSEG].above;
            err_reg         <= err_next;
            scaled_reg      <= cscaled_reg[NSEG];
        end
    end

    assign out_valid        = out_valid_reg;
    assign temperature      = temperature_reg;
    assign below_zero_input = below_reg;
    assign above_reference  = above_reg;
    assign range_error      = err_reg;
    assign scaled_code      = scaled_reg;

endmodule
`default_nettype wire

/* design/tcl_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks on the result channel of thermocouple_code_linearizer,
// bound to the top level. Depends on tcl_pkg.
module tcl_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [15:0] temperature,
    input wire logic        below_zero_input,
    input wire logic        above_reference,
    input wire logic        range_error
);

    // hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(temperature))
        else $error("stalled result changed");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && range_error |-> temperature == 16'd0)
        else $error("range error with nonzero temperature");

    a_above_neg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && above_reference |-> below_zero_input)
        else $error("above_reference outside negative branch");

    a_neg_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && below_zero_input && !range_error
            |-> temperature <= tcl_pkg::T_NEG_LIMIT)
        else $error("negative branch result above limit");

endmodule

bind thermocouple_code_linearizer tcl_checker u_tcl_checker (.*);
`default_nettype wire

/* sim/thermocouple_code_linearizer_tb.sv */
`timescale 1ns / 1ps
// Testbench for thermocouple_code_linearizer: directed codes for every sensor
// type and random codes for K, J and T, checked against an in-bench linearizer.
// Depends on tcl_pkg and the thermocouple_code_linearizer RTL.
module thermocouple_code_linearizer_tb;

    localparam int PIPE_DEPTH = 36;
    localparam int AW         = tcl_pkg::ADC_BITS;

    typedef struct {
        logic [15:0] temperature;
        logic        below;
        logic        above;
        logic        err;
        logic [15:0] scaled;
    } reading_t;

    typedef struct {
        int unsigned thr;
        int unsigned off;
        int unsigned slope;
        bit          sub;
    } seg_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [1:0]           sensor_type;
    logic                 in_valid;
    logic                 in_stall;
    logic signed [AW-1:0] adc_code;
    logic                 out_valid;
    logic                 out_stall;
    logic [15:0]          temperature;
    logic                 below_zero_input;
    logic                 above_reference;
    logic                 range_error;
    logic [15:0]          scaled_code;

    seg_t k_tab [30];
    seg_t j_tab [16];
    seg_t tn_tab [17];
    seg_t tp_tab [9];

    logic [1:0] cur_type;
    reading_t   pending_readings[$];
    int         idle_pct;
    int         stall_pct;
    int         mismatches;
    int         results_seen;
    int         items_sent;

    thermocouple_code_linearizer u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .sensor_type      (sensor_type),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .adc_code         (adc_code),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .temperature      (temperature),
        .below_zero_input (below_zero_input),
        .above_reference  (above_reference),
        .range_error      (range_error),
        .scaled_code      (scaled_code)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    function automatic seg_t mk(int unsigned t, int unsigned o, int unsigned s, bit sb);
        seg_t r;
        r.thr = t;
        r.off = o;
        r.slope = s;
        r.sub = sb;
        return r;
    endfunction

    function automatic longint floor_by(longint n, longint d);
        longint q;
        q = n / d;
        if (n < 0 && q * d != n)
            q = q - 1;
        return q;
    endfunction

    // Walk one breakpoint chain; running selects the accumulated value as test input.
    function automatic logic [15:0] walk(ref seg_t tab[], input logic [15:0] base,
                                          input bit running);
        logic [15:0] acc;
        logic [15:0] x;
        logic [15:0] q;
        acc = base;
        foreach (tab[i])
        begin
            x = running ? acc : base;
            if (x > tab[i].thr)
            begin
                q = 16'(x - 16'(tab[i].off)) / 16'(tab[i].slope);
                acc = tab[i].sub ? acc - q : acc + q;
            end
        end
        return acc;
    endfunction

    function automatic reading_t linearize(logic [1:0] st, logic signed [AW-1:0] code);
        reading_t    r;
        longint      c;
        logic [15:0] m;
        logic [15:0] t;
        int unsigned quo;
        seg_t        tab[];
        r = '{default: '0};
        c = code;
        if (st == tcl_pkg::TYPE_K)
        begin
            r.scaled = 16'(floor_by(c * 100, tcl_pkg::DIV_K) + 320);
            tab = k_tab;
            r.temperature = walk(tab, r.scaled, 0);
        end
        else if (st == tcl_pkg::TYPE_J)
        begin
            r.scaled = 16'(floor_by(c * 100, tcl_pkg::DIV_J) + 320);
            tab = j_tab;
            r.temperature = walk(tab, r.scaled, 0);
        end
        else if (st == tcl_pkg::TYPE_T)
        begin
            if (c < 0)
            begin
                m = ~code[15:0];
                r.below = 1'b1;
                if (m <= tcl_pkg::T_NEG_REF)
                begin
                    quo = (int'(m) * 100 + tcl_pkg::DIV_TN - 1) / tcl_pkg::DIV_TN;
                    t = 16'(320 - quo);
                    r.scaled = t;
                    t = t - 16'(tcl_pkg::T_NEG_KNEE - t) / 16'(tcl_pkg::T_NEG_DIV);
                end
                else
                begin
                    quo = (int'(m) * 100) / tcl_pkg::DIV_TN;
                    r.above = 1'b1;
                    t = 16'(quo - 320);
                    r.scaled = t;
                    t = t + 16'(t + tcl_pkg::T_NEG_KNEE) / 16'(tcl_pkg::T_NEG_DIV);
                    tab = tn_tab;
                    t = walk(tab, t, 1);
                end
                if (t > tcl_pkg::T_NEG_LIMIT)
                begin
                    t = 0;
                    r.err = 1'b1;
                end
                r.temperature = t;
            end
            else
            begin
                r.scaled = 16'(floor_by(c * 100, tcl_pkg::DIV_TP) + 320);
                if (c <= 11000)
                begin
                    tab = tp_tab;
                    t = walk(tab, r.scaled, 1);
                    if (t > tcl_pkg::T_POS_LIMIT)
                    begin
                        t = 0;
                        r.err = 1'b1;
                    end
                    r.temperature = t;
                end
                else
                    r.err = 1'b1;
            end
        end
        else
            r.err = 1'b1;
        return r;
    endfunction

    // Receiver: stall at random, compare each transfer with the oldest expectation.
    always @(posedge clk)
    begin
        reading_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_readings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result temp=%0d", temperature);
            end
            else
            begin
                e = pending_readings.pop_front();
                if (temperature !== e.temperature || below_zero_input !== e.below ||
                    above_reference !== e.above || range_error !== e.err ||
                    scaled_code !== e.scaled)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp t=%0d b=%0b a=%0b e=%0b s=%0d, ",
                                  "got t=%0d b=%0b a=%0b e=%0b s=%0d"},
                                 e.temperature, e.below, e.above, e.err, e.scaled,
                                 temperature, below_zero_input, above_reference,
                                 range_error, scaled_code);
                end
            end
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_code(logic signed [AW-1:0] code);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        adc_code <= code;
        do
            @(posedge clk);
        while (in_stall);
        pending_readings.push_back(linearize(cur_type, code));
        items_sent++;
    endtask

    // Drop valid, wait for every result, then let the pipeline empty out.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 4) @(posedge clk);
    endtask

    task automatic write_type(logic [1:0] st);
        drain();
        cfg_valid <= 1'b1;
        sensor_type <= st;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_type = st;
    endtask

    function automatic logic signed [AW-1:0] pick_code();
        case ($urandom_range(5))
            0: return AW'($urandom);
            1: return AW'($urandom_range(12000));
            2: return -AW'($urandom_range(900, 1));
            3: return -AW'($urandom_range(131072, 900));
            4: return AW'($urandom_range(60000));
            default: return AW'($urandom_range(131071, 11000));
        endcase
    endfunction

    task automatic test_directed_type(logic [1:0] st);
        write_type(st);
        send_code(-131072);
        send_code(131071);
        send_code(0);
        send_code(-1);
        send_code(-695);
        send_code(-696);
        send_code(11000);
        send_code(11001);
    endtask

    task automatic test_unused_type();
        write_type(tcl_pkg::TYPE_UNUSED);
        send_code(1234);
        send_code(-1234);
    endtask

    task automatic test_random_phase(int idle, int stall, int count);
        idle_pct = idle;
        stall_pct = stall;
        for (int p = 0; p < 4; p++)
        begin
            write_type(p == 3 ? tcl_pkg::TYPE_T : 2'(p));
            for (int i = 0; i < count / 4; i++)
                send_code(pick_code());
        end
    endtask

    initial
    begin
        k_tab = '{mk(760,700,36,1),mk(1350,1250,76,1),mk(2450,2350,56,0),
            mk(3268,3150,48,0),mk(4200,4100,88,1),mk(4950,4800,64,1),
            mk(5500,5450,88,1),mk(6586,6460,76,1),mk(7680,7600,120,1),
            mk(9343,9220,200,1),mk(11120,11030,200,0),mk(12310,12240,200,0),
            mk(12860,12680,120,0),mk(13780,13540,120,0),mk(14330,14300,200,0),
            mk(15050,14900,104,0),mk(15850,15660,88,0),mk(16704,16580,88,0),
            mk(17480,17280,88,0),mk(18250,18100,76,0),mk(19246,19160,64,0),
            mk(20126,20100,88,0),mk(20810,20740,48,0),mk(21810,21760,56,0),
            mk(22570,22480,56,0),mk(23020,22840,76,0),mk(23556,23440,48,0),
            mk(24350,24300,56,0),mk(24560,24420,56,0),mk(25000,24860,64,1)};
        j_tab = '{mk(854,730,32,1),mk(1340,1250,48,1),mk(1610,1530,160,1),
            mk(2445,2330,52,1),mk(3698,3550,112,1),mk(5668,5450,200,0),
            mk(7260,7160,255,0),mk(8430,8260,160,1),mk(9550,9450,112,1),
            mk(10550,10470,112,1),mk(10950,10850,112,1),mk(11550,11480,52,1),
            mk(12355,12240,52,1),mk(13193,13050,52,1),mk(14050,13950,48,1),
            mk(14920,14750,112,1)};
        tn_tab = '{mk(110,100,16,0),mk(437,420,48,0),mk(600,550,32,0),
            mk(734,710,24,0),mk(960,950,32,0),mk(1150,1100,24,0),
            mk(1350,1300,32,0),mk(1540,1520,16,0),mk(1780,1750,24,0),
            mk(1910,1900,16,0),mk(2180,2160,16,0),mk(2280,2270,16,0),
            mk(2550,2520,32,0),mk(2720,2600,16,0),mk(2890,2850,10,0),
            mk(2970,2840,48,0),mk(3150,3130,10,0)};
        tp_tab = '{mk(680,610,32,1),mk(940,910,24,1),mk(1300,1270,24,1),
            mk(1720,1700,24,1),mk(2170,2150,28,1),mk(2610,2580,32,1),
            mk(2980,2960,32,1),mk(3511,3410,32,1),mk(3984,3870,48,1)};

        rst_n = 1'b0;
        cfg_valid = 1'b0;
        sensor_type = tcl_pkg::TYPE_K;
        in_valid = 1'b0;
        adc_code = '0;
        out_stall = 1'b0;
        cur_type = tcl_pkg::TYPE_K;
        idle_pct = 0;
        stall_pct = 0;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_type(tcl_pkg::TYPE_K);
        test_directed_type(tcl_pkg::TYPE_J);
        test_directed_type(tcl_pkg::TYPE_T);
        test_unused_type();
        test_random_phase(0, 0, 200);
        test_random_phase(76, 0, 200);
        test_random_phase(0, 76, 200);
        test_random_phase(10, 10, 200);
        write_type(tcl_pkg::TYPE_K);
        idle_pct = 0;
        stall_pct = 0;
        drain();

        $display("Sent %0d codes over types K, J, T and unused, %0d results checked,",
                 items_sent, results_seen);
        $display("with sender gaps and receiver stalls in separate and combined phases.");
        if (mismatches == 0 && pending_readings.size() == 0)
            $display("SUCCESS");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("FAILURE");
        end
        $finish;
    end
endmodule
